>>> hdl/binary_heap_priority_queue_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the heap queue RTL.
// ---------------------------------------------------------------------------
`ifndef BINARY_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH

// same-cycle implication
`define BHPQ_ASSERT_NOW(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define BHPQ_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

>>> hdl/bhpq_pkg.sv
// ---------------------------------------------------------------------------
// bhpq_pkg
// Types, codes and helpers of the binary heap priority queue.
// ---------------------------------------------------------------------------
package bhpq_pkg;

   localparam int KEY_W            = 32;
   localparam int TAG_W            = 16;
   localparam int ACT_W            = 2;
   localparam int STAT_W           = 2;
   localparam int FILL_W           = 11;
   localparam int CAPACITY_DEFAULT = 1024;
   localparam int LEVELS_DEFAULT   = $clog2(CAPACITY_DEFAULT + 1);

   typedef enum logic [ACT_W-1:0] {
      ACT_PUSH  = 2'd0,
      ACT_POP   = 2'd1,
      ACT_CLEAR = 2'd2
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PUSH_GO,
      S_POP_RD,
      S_POP_GO,
      S_SIFT
   } state_type;

   // message kind traveling between neighbor cells
   typedef enum logic {
      MSG_SIFT,
      MSG_WRITE
   } kind_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [TAG_W-1:0]        tag;
   } item_type;

   localparam int ITEM_W = $bits(item_type);

   typedef struct packed {
      logic [ACT_W-1:0]        action;
      logic signed [KEY_W-1:0] key;
      logic [TAG_W-1:0]        tag;
   } req_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] out_key;
      logic [TAG_W-1:0]        out_tag;
      logic                    out_valid;
      logic [STAT_W-1:0]       status;
      logic [FILL_W-1:0]       fill_count;
   } rsp_type;

   // one message on a link of the cell row
   typedef struct packed {
      logic     valid;
      kind_type kind;
      logic     last;
      item_type item;
   } msg_type;

   // controller injection into one cell
   typedef struct packed {
      logic     valid;
      logic     below;
      kind_type kind;
      logic     last;
   } inj_type;

   // true when key x sits strictly above key y
   function automatic logic ranks_before(logic signed [KEY_W-1:0] x,
                                         logic signed [KEY_W-1:0] y,
                                         logic                    mode);
      return mode ? (x > y) : (x < y);
   endfunction

   // a sift message that leaves the end of the row lands as a final write
   function automatic msg_type to_write(msg_type m);
      msg_type w;
      w      = m;
      w.kind = MSG_WRITE;
      w.last = 1'b1;
      return w;
   endfunction

endpackage

>>> hdl/bhpq_ram.sv
// ---------------------------------------------------------------------------
// bhpq_ram
// Generic RAM: one write port, two read ports, registered read data.
// ---------------------------------------------------------------------------
module bhpq_ram #(
   parameter int WIDTH    = bhpq_pkg::ITEM_W,
   parameter int DEPTH    = 1,
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en_a,
   input  logic [ADDR_W-1:0] rd_addr_a,
   output logic [WIDTH-1:0]  rd_data_a,
   input  logic              rd_en_b,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [WIDTH-1:0]  rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // storage and read registers
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en_a) begin
         rd_a_ff <= mem_ff[rd_addr_a];
      end
      if (rd_en_b) begin
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

>>> hdl/bhpq_cell.sv
// ---------------------------------------------------------------------------
// bhpq_cell
// One heap level: its slots in a RAM plus the compare step of a sift.
// ---------------------------------------------------------------------------
`include "binary_heap_priority_queue_top_assert.svh"

module bhpq_cell #(
   parameter int LEVEL  = 0,
   parameter int LEVELS = bhpq_pkg::LEVELS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                mode,
   input  logic [LEVELS-1:0]   count,
   input  bhpq_pkg::msg_type   above_msg,
   input  logic [LEVELS-2:0]   above_ofs,
   input  bhpq_pkg::msg_type   below_msg,
   input  logic [LEVELS-2:0]   below_ofs,
   input  logic                probe_valid,
   input  logic [LEVELS-2:0]   probe_ofs,
   output bhpq_pkg::msg_type   up_msg,
   output logic [LEVELS-2:0]   up_ofs,
   output bhpq_pkg::msg_type   dn_msg,
   output logic [LEVELS-2:0]   dn_ofs,
   output bhpq_pkg::item_type  rd_item,
   output logic                final_wr
);

   import bhpq_pkg::*;

   localparam int OW    = LEVELS - 1;
   localparam int DEPTH = 1 << LEVEL;
   localparam int AW    = (LEVEL > 0) ? LEVEL : 1;
   localparam int IW    = LEVELS + 1;

   logic          tok_above, tok_below, wr_above, wr_below;
   logic [OW:0]   child_l_full, child_r_full, pick_full;
   logic [OW-1:0] parent_full;
   logic          we, rd_en_a;
   logic [AW-1:0] wr_addr, rd_addr_a;
   item_type      wr_item;
   logic [ITEM_W-1:0] rdata_a, rdata_b;
   item_type      item_a, item_b;

   logic          pend_valid_ff, pend_valid_in;
   logic          pend_pop_ff;
   item_type      pend_item_ff;
   logic [OW-1:0] pend_ofs_ff;

   logic [IW-1:0] left_idx, right_idx, cnt_ext;
   logic          l_ok, r_ok, lb, rb, swap, pick_r, up;

   // decode arriving messages
   assign tok_above = above_msg.valid && (above_msg.kind == MSG_SIFT);
   assign tok_below = below_msg.valid && (below_msg.kind == MSG_SIFT);
   assign wr_above  = above_msg.valid && (above_msg.kind == MSG_WRITE);
   assign wr_below  = below_msg.valid && (below_msg.kind == MSG_WRITE);
   assign final_wr  = (wr_above && above_msg.last) || (wr_below && below_msg.last);

   // slot addresses: children of a parent above, parent of a slot below
   assign child_l_full = {above_ofs, 1'b0};
   assign child_r_full = {above_ofs, 1'b1};
   assign parent_full  = below_ofs >> 1;

   always_comb begin
      rd_en_a   = tok_above || tok_below || probe_valid;
      rd_addr_a = probe_ofs[AW-1:0];
      if (tok_above) begin
         rd_addr_a = child_l_full[AW-1:0];
      end else if (tok_below) begin
         rd_addr_a = parent_full[AW-1:0];
      end
      we      = wr_above || wr_below;
      wr_addr = wr_above ? above_ofs[AW-1:0] : below_ofs[AW-1:0];
      wr_item = wr_above ? above_msg.item : below_msg.item;
   end

   bhpq_ram #(
      .WIDTH (ITEM_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock     (clock),
      .wr_en     (we),
      .wr_addr   (wr_addr),
      .wr_data   (wr_item),
      .rd_en_a   (rd_en_a),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rdata_a),
      .rd_en_b   (tok_above),
      .rd_addr_b (child_r_full[AW-1:0]),
      .rd_data_b (rdata_b)
   );

   assign item_a  = item_type'(rdata_a);
   assign item_b  = item_type'(rdata_b);
   assign rd_item = item_a;

   // sift request waiting for its read data
   assign pend_valid_in = tok_above || tok_below;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_valid_in) begin
         pend_pop_ff  <= tok_above;
         pend_item_ff <= tok_above ? above_msg.item : below_msg.item;
         pend_ofs_ff  <= tok_above ? above_ofs : below_ofs;
      end
   end

   // compare step
   always_comb begin
      cnt_ext   = IW'(count);
      left_idx  = (IW'(1) << LEVEL) | IW'({pend_ofs_ff, 1'b0});
      right_idx = left_idx | IW'(1);
      l_ok      = left_idx <= cnt_ext;
      r_ok      = right_idx <= cnt_ext;
      lb        = ranks_before(item_a.key, pend_item_ff.key, mode);
      rb        = r_ok && ranks_before(item_b.key, pend_item_ff.key, mode);
      swap      = l_ok && (lb || rb);
      pick_r    = r_ok && ranks_before(item_b.key, item_a.key, mode);
      pick_full = {pend_ofs_ff, pick_r};
      up        = ranks_before(pend_item_ff.key, item_a.key, mode);
   end

   // messages to the neighbors
   always_comb begin
      up_msg = '0;
      dn_msg = '0;
      up_ofs = '0;
      dn_ofs = '0;
      if (pend_valid_ff && pend_pop_ff) begin
         // sift down: better child moves up into the parent slot
         up_msg.valid = 1'b1;
         up_msg.kind  = MSG_WRITE;
         up_msg.last  = !swap;
         up_msg.item  = swap ? (pick_r ? item_b : item_a) : pend_item_ff;
         up_ofs       = pend_ofs_ff;
         dn_msg.valid = swap;
         dn_msg.kind  = MSG_SIFT;
         dn_msg.item  = pend_item_ff;
         dn_ofs       = pick_full[OW-1:0];
      end else if (pend_valid_ff) begin
         // sift up: parent moves down into the child slot
         dn_msg.valid = 1'b1;
         dn_msg.kind  = MSG_WRITE;
         dn_msg.last  = !up;
         dn_msg.item  = up ? item_a : pend_item_ff;
         dn_ofs       = pend_ofs_ff;
         up_msg.valid = up;
         up_msg.kind  = MSG_SIFT;
         up_msg.item  = pend_item_ff;
         up_ofs       = pend_ofs_ff >> 1;
      end
   end

   `BHPQ_ASSERT_NOW(a_one_link, clock, reset, above_msg.valid, !below_msg.valid, "two messages at once")
   `BHPQ_ASSERT_NOW(a_no_overlap, clock, reset, pend_valid_ff, !pend_valid_in, "sift arrives during compare")

endmodule

>>> hdl/binary_heap_priority_queue_top.sv
// ---------------------------------------------------------------------------
// binary_heap_priority_queue_top
// Binary heap priority queue of key/tag pairs built as a row of level cells.
//
//   channel   ports                           transfer
//   request   start, busy, req_data           start && !busy
//   result    rsp_strobe, rsp_data            rsp_strobe, one cycle each
//   config    csr_valid, csr_ready, csr_data  csr_valid && csr_ready
//
// Clear, no-op and rejected actions answer one cycle after acceptance.
// Push and pop sift through the cell row one heap level at a time, each
// level one compare after a registered RAM read. Reset is synchronous and
// empties the heap at once; slot contents are not cleared. The result side
// cannot stall.
// ---------------------------------------------------------------------------
`include "binary_heap_priority_queue_top_assert.svh"

module binary_heap_priority_queue_top #(
   parameter int CAPACITY = bhpq_pkg::CAPACITY_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bhpq_pkg::req_type req_data,
   output logic              rsp_strobe,
   output bhpq_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_data
);

   import bhpq_pkg::*;

   localparam int LEVELS = $clog2(CAPACITY + 1);
   localparam int OW     = LEVELS - 1;
   localparam int LW     = $clog2(LEVELS);

   localparam logic [LEVELS-1:0] CAP_CNT = LEVELS'(CAPACITY);

   // controller registers
   state_type         state_ff, state_in;
   logic [LEVELS-1:0] count_ff, count_in;
   logic              mode_ff;
   item_type          item_ff, item_in;
   item_type          pop_item_ff, pop_item_in;
   logic              popped_ff, popped_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_type           rsp_ff, rsp_in;

   // cell row links
   msg_type           up_msg [LEVELS];
   msg_type           dn_msg [LEVELS];
   logic [OW-1:0]     up_ofs [LEVELS];
   logic [OW-1:0]     dn_ofs [LEVELS];
   item_type          rd_item [LEVELS];
   logic [LEVELS-1:0] final_wr;

   // injection and probe controls
   inj_type           inj;
   logic [LW-1:0]     inj_level;
   logic [OW-1:0]     inj_ofs;
   item_type          inj_item;
   msg_type           inj_msg;
   logic              probe_go;

   logic [LW-1:0]     lev;
   logic [LEVELS-1:0] off_full;
   logic [OW-1:0]     off;

   // configuration register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_valid) begin
         mode_ff <= csr_data;
      end
   end

   // level and in-level offset of slot count_ff
   always_comb begin
      lev = '0;
      for (int i = 0; i < LEVELS; i++) begin
         if (count_ff[i]) begin
            lev = LW'(i);
         end
      end
      off_full = count_ff & ~(LEVELS'(1) << lev);
      off      = off_full[OW-1:0];
   end

   // next state and outputs
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      item_in       = item_ff;
      pop_item_in   = pop_item_ff;
      popped_in     = popped_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      inj           = '0;
      inj_level     = '0;
      inj_ofs       = '0;
      inj_item      = item_ff;
      probe_go      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               rsp_in            = '0;
               rsp_in.fill_count = FILL_W'(count_ff);
               unique case (req_data.action)
                  ACT_PUSH: begin
                     if (count_ff >= CAP_CNT) begin
                        rsp_in.status = ST_FULL;
                        rsp_strobe_in = 1'b1;
                     end else begin
                        count_in = count_ff + LEVELS'(1);
                        item_in  = '{key: req_data.key, tag: req_data.tag};
                        state_in = S_PUSH_GO;
                     end
                  end
                  ACT_POP: begin
                     if (count_ff == '0) begin
                        rsp_in.status = ST_EMPTY;
                        rsp_strobe_in = 1'b1;
                     end else begin
                        state_in = S_POP_RD;
                     end
                  end
                  ACT_CLEAR: begin
                     count_in          = '0;
                     rsp_in.fill_count = '0;
                     rsp_strobe_in     = 1'b1;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         S_PUSH_GO: begin
            popped_in = 1'b0;
            inj.valid = 1'b1;
            if (lev == '0) begin
               // first item goes straight to the root
               inj.kind          = MSG_WRITE;
               inj.last          = 1'b1;
               rsp_in            = '0;
               rsp_in.fill_count = FILL_W'(count_ff);
               rsp_strobe_in     = 1'b1;
               state_in          = S_IDLE;
            end else begin
               inj.below = 1'b1;
               inj.kind  = MSG_SIFT;
               inj_level = lev - LW'(1);
               inj_ofs   = off;
               state_in  = S_SIFT;
            end
         end
         S_POP_RD: begin
            probe_go = 1'b1;
            state_in = S_POP_GO;
         end
         S_POP_GO: begin
            pop_item_in = rd_item[0];
            popped_in   = 1'b1;
            count_in    = count_ff - LEVELS'(1);
            if (count_ff == LEVELS'(1)) begin
               rsp_in.out_key    = rd_item[0].key;
               rsp_in.out_tag    = rd_item[0].tag;
               rsp_in.out_valid  = 1'b1;
               rsp_in.status     = ST_OK;
               rsp_in.fill_count = '0;
               rsp_strobe_in     = 1'b1;
               state_in          = S_IDLE;
            end else begin
               // last item enters at the root and sifts down
               inj.valid = 1'b1;
               inj.kind  = MSG_SIFT;
               inj_level = LW'(1);
               inj_item  = rd_item[lev];
               state_in  = S_SIFT;
            end
         end
         S_SIFT: begin
            if (|final_wr) begin
               rsp_in.out_key    = popped_ff ? pop_item_ff.key : '0;
               rsp_in.out_tag    = popped_ff ? pop_item_ff.tag : '0;
               rsp_in.out_valid  = popped_ff;
               rsp_in.status     = ST_OK;
               rsp_in.fill_count = FILL_W'(count_ff);
               rsp_strobe_in     = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
         popped_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
         popped_ff     <= popped_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      pop_item_ff <= pop_item_in;
      rsp_ff      <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   assign inj_msg = '{valid: inj.valid, kind: inj.kind, last: inj.last, item: inj_item};

   // row of level cells
   for (genvar g = 0; g < LEVELS; g++) begin : g_cell
      msg_type       nb_above, nb_below, ab_msg, bl_msg;
      logic [OW-1:0] nb_above_ofs, nb_below_ofs, ab_ofs, bl_ofs;
      logic          inj_here;
      logic          probe_v;
      logic [OW-1:0] probe_ofs;

      // top of the row folds its upward sift back as a write
      if (g == 0) begin : g_top
         assign nb_above     = to_write(up_msg[g]);
         assign nb_above_ofs = up_ofs[g];
      end else begin : g_mid_a
         assign nb_above     = dn_msg[g-1];
         assign nb_above_ofs = dn_ofs[g-1];
      end

      // bottom of the row folds its downward sift back as a write
      if (g == LEVELS - 1) begin : g_bot
         assign nb_below     = to_write(dn_msg[g]);
         assign nb_below_ofs = dn_ofs[g];
      end else begin : g_mid_b
         assign nb_below     = up_msg[g+1];
         assign nb_below_ofs = up_ofs[g+1];
      end

      assign inj_here  = inj.valid && (inj_level == LW'(g));
      assign ab_msg    = (inj_here && !inj.below) ? inj_msg : nb_above;
      assign ab_ofs    = (inj_here && !inj.below) ? inj_ofs : nb_above_ofs;
      assign bl_msg    = (inj_here && inj.below) ? inj_msg : nb_below;
      assign bl_ofs    = (inj_here && inj.below) ? inj_ofs : nb_below_ofs;
      assign probe_v   = probe_go && ((g == 0) || (lev == LW'(g)));
      assign probe_ofs = (lev == LW'(g)) ? off : '0;

      bhpq_cell #(
         .LEVEL  (g),
         .LEVELS (LEVELS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .mode        (mode_ff),
         .count       (count_ff),
         .above_msg   (ab_msg),
         .above_ofs   (ab_ofs),
         .below_msg   (bl_msg),
         .below_ofs   (bl_ofs),
         .probe_valid (probe_v),
         .probe_ofs   (probe_ofs),
         .up_msg      (up_msg[g]),
         .up_ofs      (up_ofs[g]),
         .dn_msg      (dn_msg[g]),
         .dn_ofs      (dn_ofs[g]),
         .rd_item     (rd_item[g]),
         .final_wr    (final_wr[g])
      );
   end

   `BHPQ_ASSERT_NOW(a_done_in_sift, clock, reset, |final_wr, (state_ff == S_SIFT) || (state_ff == S_PUSH_GO), "final write outside a sift")
   `BHPQ_ASSERT_NEXT(a_full_push, clock, reset, start && !busy && (req_data.action == ACT_PUSH) && (count_ff == CAP_CNT), rsp_strobe && (rsp_data.status == ST_FULL), "full push not flagged")
   `BHPQ_ASSERT_NOW(a_rsp_idle, clock, reset, rsp_strobe, !busy, "result while busy")

endmodule

>>> dv/binary_heap_priority_queue_top_tb.sv
// ---------------------------------------------------------------------------
// binary_heap_priority_queue_top_tb
// Self-checking bench for the heap priority queue. A backlog of push, pop,
// clear and no-op commands feeds a clocked driver. Every accepted command is
// run through a local heap model, and the monitor checks each result strobe
// against the oldest predicted result. Min and max order are both exercised,
// including an order change while items are held and a heap grown past 512
// items.
// ---------------------------------------------------------------------------
module binary_heap_priority_queue_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bhpq_pkg::*;

   localparam int CAPACITY      = CAPACITY_DEFAULT;
   localparam int SETTLE_CYCLES = 24;
   localparam int QUIET_LIMIT   = 4000;

   // action code 3 is unused by the block and must act as a no-op
   localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;

   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

   logic    clock;
   logic    reset     = 1'b1;
   logic    start     = 1'b0;
   logic    busy;
   req_type req_data  = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic    csr_data  = 1'b0;

   binary_heap_priority_queue_top #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Heap model: own copy of the slots, fill count and order bit
   // ------------------------------------------------------------------------
   logic signed [KEY_W-1:0] slot_key [1:CAPACITY];
   logic [TAG_W-1:0]        slot_tag [1:CAPACITY];
   int                      held_items = 0;
   logic                    order_max  = 1'b0;

   req_type cmd_backlog [$];
   rsp_type rsp_expected [$];
   int      idle_pct    = 32;
   int      error_count = 0;
   int      quiet_cycles = 0;

   // x must sit strictly above y under the current order
   function automatic logic outranks(logic signed [KEY_W-1:0] x,
                                     logic signed [KEY_W-1:0] y);
      if (order_max) return x > y;
      return x < y;
   endfunction

   function automatic void swap_slots(int i, int j);
      logic signed [KEY_W-1:0] k;
      logic [TAG_W-1:0]        t;
      k           = slot_key[i];
      t           = slot_tag[i];
      slot_key[i] = slot_key[j];
      slot_tag[i] = slot_tag[j];
      slot_key[j] = k;
      slot_tag[j] = t;
   endfunction

   // apply one command to the model, return the result it must produce
   function automatic rsp_type heap_apply(req_type cmd);
      rsp_type res;
      int      a;
      int      l;
      int      r;
      int      pick;
      logic    lb;
      logic    rb;
      res = '0;
      case (cmd.action)
         ACT_PUSH: begin
            if (held_items >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               held_items++;
               a = held_items;
               slot_key[a] = cmd.key;
               slot_tag[a] = cmd.tag;
               // sift up, stop on equal keys
               while (a > 1 && outranks(slot_key[a], slot_key[a/2])) begin
                  swap_slots(a, a/2);
                  a = a / 2;
               end
            end
         end
         ACT_POP: begin
            if (held_items == 0) begin
               res.status = ST_EMPTY;
            end else begin
               res.out_key   = slot_key[1];
               res.out_tag   = slot_tag[1];
               res.out_valid = 1'b1;
               slot_key[1]   = slot_key[held_items];
               slot_tag[1]   = slot_tag[held_items];
               held_items--;
               a = 1;
               // sift down, left child wins a tie
               forever begin
                  l = 2 * a;
                  r = 2 * a + 1;
                  if (l > held_items) break;
                  lb = outranks(slot_key[l], slot_key[a]);
                  rb = (r <= held_items) && outranks(slot_key[r], slot_key[a]);
                  if (!lb && !rb) break;
                  if (r <= held_items && outranks(slot_key[r], slot_key[l])) pick = r;
                  else pick = l;
                  swap_slots(a, pick);
                  a = pick;
               end
            end
         end
         ACT_CLEAR: begin
            held_items = 0;
         end
         default: begin
         end
      endcase
      res.fill_count = held_items[FILL_W-1:0];
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Driver: one command per start/!busy transfer, random idle gaps
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : cmd_driver
      logic go;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) rsp_expected.push_back(heap_apply(req_data));
         go = start && busy;
         if (!go && cmd_backlog.size() > 0 && $urandom_range(99) >= idle_pct) begin
            req_data <= cmd_backlog.pop_front();
            go = 1'b1;
         end
         start <= go;
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: every strobe is checked against the oldest prediction
   // ------------------------------------------------------------------------
   task automatic log_error(string what, rsp_type want, rsp_type got);
      error_count++;
      if (error_count <= 10)
         $display("%0t %s: expected key=%0d tag=%h valid=%b status=%0d fill=%0d, got key=%0d tag=%h valid=%b status=%0d fill=%0d",
                  $realtime, what, want.out_key, want.out_tag, want.out_valid, want.status,
                  want.fill_count, got.out_key, got.out_tag, got.out_valid, got.status,
                  got.fill_count);
   endtask

   always @(posedge clock) begin : rsp_monitor
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (rsp_expected.size() == 0) begin
            log_error("unexpected result", '0, rsp_data);
         end else begin
            want = rsp_expected.pop_front();
            if (rsp_data.out_key !== want.out_key || rsp_data.out_tag !== want.out_tag ||
                rsp_data.out_valid !== want.out_valid || rsp_data.status !== want.status ||
                rsp_data.fill_count !== want.fill_count)
               log_error("result mismatch", want, rsp_data);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: cycles without any transfer on any channel
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("binary_heap_priority_queue_top_tb: errors");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic queue_cmd(logic [ACT_W-1:0] act, logic signed [KEY_W-1:0] k,
                            logic [TAG_W-1:0] t);
      req_type cmd;
      cmd.action = act;
      cmd.key    = k;
      cmd.tag    = t;
      cmd_backlog.push_back(cmd);
   endtask

   // small keys give many ties, extremes hit the compare edges
   function automatic logic signed [KEY_W-1:0] draw_key();
      logic signed [KEY_W-1:0] k;
      case ($urandom_range(7))
         0, 1: begin
            k = $urandom_range(4);
            k = k - 2;
         end
         2: begin
            case ($urandom_range(3))
               0:       k = KEY_MIN;
               1:       k = KEY_MAX;
               2:       k = KEY_MIN + 1;
               default: k = KEY_MAX - 1;
            endcase
         end
         default: k = $urandom;
      endcase
      return k;
   endfunction

   task automatic queue_random(int count, int push_w);
      int sel;
      repeat (count) begin
         sel = $urandom_range(99);
         if (sel < push_w)  queue_cmd(ACT_PUSH, draw_key(), 16'($urandom));
         else if (sel < 98) queue_cmd(ACT_POP, $urandom, 16'($urandom));
         else if (sel < 99) queue_cmd(ACT_CLEAR, $urandom, 16'($urandom));
         else               queue_cmd(ACT_NOP, $urandom, 16'($urandom));
      end
   endtask

   // wait until every queued command is transferred and answered
   task automatic settle();
      @(negedge clock);
      while (cmd_backlog.size() != 0 || start || rsp_expected.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // order register write, only called with the block idle
   task automatic write_order(logic mode);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= mode;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      order_max = mode;
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed, min order from reset
      queue_cmd(ACT_POP,   0,        16'h0000);   // pop on empty heap
      queue_cmd(ACT_PUSH,  KEY_MAX,  16'hFFFF);
      queue_cmd(ACT_PUSH,  KEY_MIN,  16'h0000);
      queue_cmd(ACT_PUSH,  0,        16'h1234);
      queue_cmd(ACT_PUSH,  0,        16'h5555);   // sifts above KEY_MAX; the next push stops on its equal key
      queue_cmd(ACT_PUSH,  0,        16'hAAAA);
      queue_cmd(ACT_PUSH,  -1,       16'h00FF);
      queue_cmd(ACT_NOP,   -1,       16'hFFFF);
      queue_cmd(ACT_POP,   0,        16'h0000);
      queue_cmd(ACT_POP,   0,        16'h0000);
      queue_cmd(ACT_POP,   0,        16'h0000);   // tie between children
      queue_cmd(ACT_CLEAR, KEY_MAX,  16'hFFFF);
      queue_cmd(ACT_POP,   0,        16'h0000);   // empty again after clear
      queue_cmd(ACT_PUSH,  5,        16'h0001);
      queue_cmd(ACT_PUSH,  3,        16'h0002);
      queue_cmd(ACT_PUSH,  9,        16'h0003);
      settle();

      // switch to max order with items held: nothing is reordered
      write_order(1'b1);
      queue_cmd(ACT_PUSH,  7,        16'h0004);
      repeat (4) queue_cmd(ACT_POP, 0, 16'h0000);
      queue_cmd(ACT_POP,   0,        16'h0000);
      settle();

      // random, min order
      write_order(1'b0);
      queue_random(75, 60);
      settle();

      // random, max order, driver never idles
      write_order(1'b1);
      idle_pct = 0;
      queue_random(75, 55);
      settle();

      // back to min order with the heap still holding items
      idle_pct = 32;
      write_order(1'b0);
      queue_random(75, 45);
      settle();

      // grow a heap past 512 items in max order, then work on it
      write_order(1'b1);
      queue_cmd(ACT_CLEAR, 0, 16'h0000);
      repeat (520) queue_cmd(ACT_PUSH, draw_key(), 16'($urandom));
      repeat (30) begin
         if ($urandom_range(1)) queue_cmd(ACT_PUSH, draw_key(), 16'($urandom));
         else                   queue_cmd(ACT_POP, $urandom, 16'($urandom));
      end
      repeat (25) queue_cmd(ACT_POP, $urandom, 16'($urandom));
      settle();

      // closing random run in min order
      write_order(1'b0);
      queue_random(25, 55);
      settle();

      if (error_count == 0 && rsp_expected.size() == 0) begin
         $display("binary_heap_priority_queue_top_tb: clean");
      end else begin
         $display("binary_heap_priority_queue_top_tb: errors");
      end
      $finish;
   end

endmodule
